FILE: src/aarot_pkg.sv
// Package for the axis-angle rotation block: payload structs, CORDIC table, constants.
// No dependencies.
`timescale 1ns / 1ps
package aarot_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] angle;
    logic               is_own_dof;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  localparam int TAB_LEN = 24;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [21:0] ONE_Q20     = 22'sd1048576;
  localparam logic signed [17:0] ENTRY_MAX   = 18'sd16384;
  localparam logic signed [17:0] ENTRY_MIN   = -18'sd16384;

  localparam logic [1:0] MODE_ROT  = 2'd0;
  localparam logic [1:0] MODE_INV  = 2'd1;
  localparam logic [1:0] MODE_DER1 = 2'd2;
  localparam logic [1:0] MODE_DER2 = 2'd3;

  localparam logic [1:0] REG_AXIS_X = 2'd0;
  localparam logic [1:0] REG_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_AXIS_Z = 2'd2;

  function automatic logic signed [35:0] atan_q30(input int i);
    case (i)
      0: atan_q30 = 36'sh03243F6A8;  1: atan_q30 = 36'sh01DAC6705;
      2: atan_q30 = 36'sh00FADBAFC;  3: atan_q30 = 36'sh007F56EA6;
      4: atan_q30 = 36'sh003FEAB76;  5: atan_q30 = 36'sh001FFD55B;
      6: atan_q30 = 36'sh000FFFAAA;  7: atan_q30 = 36'sh0007FFF55;
      8: atan_q30 = 36'sh0003FFFEA;  9: atan_q30 = 36'sh0001FFFFD;
      10: atan_q30 = 36'sh0000FFFFF; 11: atan_q30 = 36'sh00007FFFF;
      12: atan_q30 = 36'sh00003FFFF; 13: atan_q30 = 36'sh00001FFFF;
      14: atan_q30 = 36'sh00000FFFF; 15: atan_q30 = 36'sh000007FFF;
      16: atan_q30 = 36'sh000003FFF; 17: atan_q30 = 36'sh000001FFF;
      18: atan_q30 = 36'sh000000FFF; 19: atan_q30 = 36'sh0000007FF;
      20: atan_q30 = 36'sh0000003FF; 21: atan_q30 = 36'sh0000001FF;
      22: atan_q30 = 36'sh0000000FF; 23: atan_q30 = 36'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

FILE: src/axis_angle_rotation_with_derivatives_top.sv
// Axis-angle rotation block: Rodrigues matrix, inverse and angle derivatives.
// Throughput: one transfer per cycle while output is not stalled; set by the unrolled
//   CORDIC pipeline, one micro-rotation per stage, followed by a 4-stage
//   coef/product/sum/saturate path.
// Reset (rst_n low, synchronous): pipeline valid bits cleared, axis = (1,0,0).
// Depends on aarot_pkg.
`timescale 1ns / 1ps
module axis_angle_rotation_with_derivatives_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aarot_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aarot_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import aarot_pkg::*;

  // Table holds 24 angles; more steps behave as 24.
  localparam int NSTEP = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  // Stages: 0 = reduction, 1..NSTEP = CORDIC, then round, product, sum, saturate.
  localparam int NST = NSTEP + 5;

  typedef struct packed {
    logic [1:0] mode;
    logic       own;
    logic       flip;
  } tag_t;

  // ---------------- configuration ----------------
  logic signed [15:0] ax_r, ay_r, az_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= 16'sd16384;
      ay_r <= '0;
      az_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS_X: ax_r <= cfg_data;
        REG_AXIS_Y: ay_r <= cfg_data;
        REG_AXIS_Z: az_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- global stall ----------------
  // Whole pipe advances together; stalls only when the output is held.
  logic adv;
  logic [NST-1:0] vld_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_valid};
  end
  assign out_valid = vld_r[NST-1];

  // ---------------- stage 0: quadrant reduction ----------------
  logic signed [35:0] x_r [NSTEP+1];
  logic signed [35:0] y_r [NSTEP+1];
  logic signed [35:0] z_r [NSTEP+1];
  tag_t               tag_r [NSTEP+1];

  logic signed [35:0] z0;
  always_comb begin
    z0 = {{3{in_data.angle[15]}}, in_data.angle, 17'd0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      tag_r[0].mode <= in_data.mode;
      tag_r[0].own  <= in_data.is_own_dof;
      if (z0 > HALF_PI_Q30) begin
        z_r[0] <= z0 - PI_Q30;
        tag_r[0].flip <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_r[0] <= z0 + PI_Q30;
        tag_r[0].flip <= 1'b1;
      end else begin
        z_r[0] <= z0;
        tag_r[0].flip <= 1'b0;
      end
    end
  end

  // ---------------- CORDIC stages ----------------
  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        tag_r[i+1] <= tag_r[i];
        if (!z_r[i][35]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  // ---------------- round to Q20, pick coefficients ----------------
  logic signed [35:0] xf, yf;
  logic signed [25:0] c_q, s_q;
  logic signed [22:0] a_nxt, b_nxt, cc_nxt;
  logic signed [22:0] a_r, b_r, cc_r;
  tag_t               t1_r;

  always_comb begin
    xf = tag_r[NSTEP].flip ? -x_r[NSTEP] : x_r[NSTEP];
    yf = tag_r[NSTEP].flip ? -y_r[NSTEP] : y_r[NSTEP];
    c_q = 26'((xf + 36'sd512) >>> 10);
    s_q = 26'((yf + 36'sd512) >>> 10);
    case (tag_r[NSTEP].mode)
      MODE_ROT: begin
        a_nxt = 23'(c_q); b_nxt = 23'(s_q); cc_nxt = 23'(ONE_Q20) - 23'(c_q);
      end
      MODE_INV: begin
        a_nxt = 23'(c_q); b_nxt = -23'(s_q); cc_nxt = 23'(ONE_Q20) - 23'(c_q);
      end
      MODE_DER1: begin
        a_nxt = -23'(s_q); b_nxt = 23'(c_q); cc_nxt = 23'(s_q);
      end
      default: begin
        a_nxt = -23'(c_q); b_nxt = -23'(s_q); cc_nxt = 23'(c_q);
      end
    endcase
  end

  // Axis products k[r]*k[j] are fixed between items; registered here.
  logic signed [31:0] kk_r [3][3];
  logic signed [15:0] kv [3];
  assign kv[0] = ax_r;
  assign kv[1] = ay_r;
  assign kv[2] = az_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      cc_r <= cc_nxt;
      t1_r <= tag_r[NSTEP];
    end
  end
  for (genvar r = 0; r < 3; r++) begin : g_kk
    for (genvar j = 0; j < 3; j++) begin : g_kkj
      always_ff @(posedge clk) kk_r[r][j] <= 32'(kv[r]) * 32'(kv[j]);
    end
  end

  // ---------------- products ----------------
  // cross[r][j] entries (signed 17 bits to hold -(-32768))
  logic signed [16:0] cr [3][3];
  always_comb begin
    cr[0][0] = '0;           cr[0][1] = -17'(az_r);  cr[0][2] = 17'(ay_r);
    cr[1][0] = 17'(az_r);    cr[1][1] = '0;          cr[1][2] = -17'(ax_r);
    cr[2][0] = -17'(ay_r);   cr[2][1] = 17'(ax_r);   cr[2][2] = '0;
  end

  logic signed [54:0] p1_r [3][3];
  logic signed [39:0] p2_r [3][3];
  logic signed [22:0] a2_r;
  tag_t               t2_r;

  for (genvar r = 0; r < 3; r++) begin : g_mul
    for (genvar j = 0; j < 3; j++) begin : g_mulj
      always_ff @(posedge clk) begin
        if (adv) begin
          p1_r[r][j] <= 55'(kk_r[r][j]) * 55'(cc_r);
          p2_r[r][j] <= 40'(cr[r][j]) * 40'(b_r);
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r <= a_r;
      t2_r <= t1_r;
    end
  end

  // ---------------- sum and round ----------------
  logic signed [58:0] sum_nxt [3][3];
  logic signed [24:0] rs_r [3][3];
  tag_t               t3_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        sum_nxt[r][j] = 59'(p1_r[r][j]) + (59'(p2_r[r][j]) <<< 14)
                        + ((r == j) ? (59'(a2_r) <<< 28) : 59'sd0)
                        + (59'sd1 <<< 33);
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_sum
    for (genvar j = 0; j < 3; j++) begin : g_sumj
      always_ff @(posedge clk) begin
        if (adv) rs_r[r][j] <= 25'(sum_nxt[r][j] >>> 34);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) t3_r <= t2_r;
  end

  // ---------------- saturate, gate derivatives ----------------
  logic [15:0] sat_nxt [3][3];
  logic        zero_out;
  out_item_t   out_r;

  always_comb begin
    zero_out = t3_r.mode[1] && !t3_r.own;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        if (zero_out) sat_nxt[r][j] = '0;
        else if (rs_r[r][j] > 25'(ENTRY_MAX)) sat_nxt[r][j] = 16'(ENTRY_MAX);
        else if (rs_r[r][j] < 25'(ENTRY_MIN)) sat_nxt[r][j] = 16'(ENTRY_MIN);
        else sat_nxt[r][j] = rs_r[r][j][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.m00 <= sat_nxt[0][0]; out_r.m01 <= sat_nxt[0][1];
      out_r.m02 <= sat_nxt[0][2]; out_r.m10 <= sat_nxt[1][0];
      out_r.m11 <= sat_nxt[1][1]; out_r.m12 <= sat_nxt[1][2];
      out_r.m20 <= sat_nxt[2][0]; out_r.m21 <= sat_nxt[2][1];
      out_r.m22 <= sat_nxt[2][2];
    end
  end
  assign out_data = out_r;

endmodule

FILE: src/aarot_checker.sv
// Port-level checker for the rotation block, bound to the top level.
// Depends on aarot_pkg.
`timescale 1ns / 1ps
module aarot_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input aarot_pkg::out_item_t out_data
);
  import aarot_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("not ready with empty output");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_data.m11) <= 16'sd16384 && $signed(out_data.m11) >= -16'sd16384)
    else $error("entry beyond saturation bound");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind axis_angle_rotation_with_derivatives_top aarot_checker u_chk (.*);

FILE: tb/tb_axis_angle_rotation_with_derivatives_top.sv
// Testbench for the axis-angle rotation block: directed table, then random transfers.
// Results are checked against an in-bench Rodrigues/CORDIC predictor. Depends on aarot_pkg.
`timescale 1ns / 1ps
module tb_axis_angle_rotation_with_derivatives_top;
  import aarot_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM = 850;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_AXIS_X;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  axis_angle_rotation_with_derivatives_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor's copy of the axis registers
  logic signed [15:0] ax_k [3];

  out_item_t expected_mats[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;     // long stretch with no idling on either side

  // Matrix entries are filled by a single predictor; directed rows with
  // a typed-in matrix cross-check the predictor too.
  typedef struct {
    logic [1:0] mode;
    int angle;
    bit own;
    bit typed;
    int diag;             // typed matrix: diag*I, all else zero
  } dir_row_t;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint fshift(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint rshift(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic void cordic_cs(input int ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    longint tab [24] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
    bit flip;
    int n;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    n = (STEPS > 24) ? 24 : STEPS;
    for (int i = 0; i < n; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= tab[i];
      end else begin
        x += ys; y -= xs; z += tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = rshift(x, 10);
    s = rshift(y, 10);
  endfunction

  function automatic out_item_t rotation_matrix(input in_item_t it);
    longint c, s, a, b, cc, v;
    longint k [3];
    longint cr [3][3];
    logic signed [15:0] e [9];
    cordic_cs(int'(it.angle), c, s);
    for (int i = 0; i < 3; i++) k[i] = ax_k[i];
    cr[0][0] = 0;     cr[0][1] = -k[2]; cr[0][2] = k[1];
    cr[1][0] = k[2];  cr[1][1] = 0;     cr[1][2] = -k[0];
    cr[2][0] = -k[1]; cr[2][1] = k[0];  cr[2][2] = 0;
    case (it.mode)
      MODE_ROT:  begin a = c;  b = s;  cc = 64'sd1048576 - c; end
      MODE_INV:  begin a = c;  b = -s; cc = 64'sd1048576 - c; end
      MODE_DER1: begin a = -s; b = c;  cc = s; end
      default:   begin a = -c; b = -s; cc = c; end
    endcase
    for (int r = 0; r < 3; r++)
      for (int j = 0; j < 3; j++) begin
        v = 0;
        if (it.mode == MODE_ROT || it.mode == MODE_INV || it.is_own_dof) begin
          v = k[r] * k[j] * cc + cr[r][j] * b * 16384;
          if (r == j) v += a * (64'sd1 <<< 28);
          v = rshift(v, 34);
          if (v > 16384) v = 16384;
          if (v < -16384) v = -16384;
        end
        e[r * 3 + j] = v[15:0];
      end
    return '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  // Sender: drives on falling edge, transfer seen at the first rising edge with in_ready high.
  // Valid stays up after the transfer; the next send, an idle cycle or
  // drain() replaces or drops it at the same falling edge.
  task automatic send(input in_item_t it, input bit idle_ok);
    while (idle_ok && !no_idle && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    expected_mats = {expected_mats, rotation_matrix(it)};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_axis(input logic [1:0] idx, input logic signed [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    ax_k[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected matrix, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_mats.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_axis(input int x, input int y, input int z);
    drain();
    write_axis(REG_AXIS_X, 16'(x));
    write_axis(REG_AXIS_Y, 16'(y));
    write_axis(REG_AXIS_Z, 16'(z));
  endtask

  function automatic in_item_t rand_item;
    in_item_t it;
    it.mode = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: it.angle = 16'($urandom());                 // anything, beyond pi too
      1: it.angle = $urandom_range(1) ? 16'sd25736 : -16'sd25736;
      2: it.angle = 16'(12868 + int'($urandom_range(8)) - 4);   // around +pi/2
      default: it.angle = 16'(int'($urandom_range(51472)) - 25736);
    endcase
    it.is_own_dof = 1'($urandom_range(1));
    return it;
  endfunction

  // Receiver with random stall
  always @(negedge clk)
    out_ready <= no_idle || ($urandom_range(99) >= 14);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_mats.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        out_item_t w;
        w = expected_mats.pop_front();
        if (out_data.m00 !== w.m00) report("m00", out_data.m00, w.m00);
        if (out_data.m01 !== w.m01) report("m01", out_data.m01, w.m01);
        if (out_data.m02 !== w.m02) report("m02", out_data.m02, w.m02);
        if (out_data.m10 !== w.m10) report("m10", out_data.m10, w.m10);
        if (out_data.m11 !== w.m11) report("m11", out_data.m11, w.m11);
        if (out_data.m12 !== w.m12) report("m12", out_data.m12, w.m12);
        if (out_data.m20 !== w.m20) report("m20", out_data.m20, w.m20);
        if (out_data.m21 !== w.m21) report("m21", out_data.m21, w.m21);
        if (out_data.m22 !== w.m22) report("m22", out_data.m22, w.m22);
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Directed table: derivative of another joint gives a typed-in zero matrix
  dir_row_t dir_rows [] = '{
    '{MODE_ROT,  0,      0, 0, 0}, '{MODE_INV,  0,      1, 0, 0},
    '{MODE_DER1, 0,      1, 0, 0}, '{MODE_DER2, 0,      1, 0, 0},
    '{MODE_DER1, 12345,  0, 1, 0}, '{MODE_DER2, -9000,  0, 1, 0},
    '{MODE_ROT,  25736,  0, 0, 0}, '{MODE_ROT,  -25736, 0, 0, 0},
    '{MODE_INV,  12868,  0, 0, 0}, '{MODE_DER1, -12868, 1, 0, 0},
    '{MODE_DER2, 12869,  1, 0, 0}, '{MODE_ROT,  32767,  1, 0, 0},
    '{MODE_INV,  -32768, 0, 0, 0}, '{MODE_DER1, 32767,  1, 0, 0},
    '{MODE_DER2, -32768, 1, 0, 0}, '{MODE_ROT,  -1,     1, 0, 0}
  };

  initial begin
    in_item_t it;
    out_item_t w;
    out_item_t typed_m;
    ax_k[0] = 16384; ax_k[1] = 0; ax_k[2] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows, reset axis
    foreach (dir_rows[i]) begin
      it.mode = dir_rows[i].mode;
      it.angle = 16'(dir_rows[i].angle);
      it.is_own_dof = dir_rows[i].own;
      if (dir_rows[i].typed) begin
        typed_m = '0;
        typed_m.m00 = 16'(dir_rows[i].diag);
        typed_m.m11 = 16'(dir_rows[i].diag);
        typed_m.m22 = 16'(dir_rows[i].diag);
        w = rotation_matrix(it);
        if (w != typed_m) report("table typed matrix", 1, 0);
      end
      send(it, 1'b1);
    end

    // Axis extremes and a non-unit axis
    set_axis(-16384, 0, 0);
    send('{MODE_ROT, 16'sd6434, 1'b0}, 1'b1);
    set_axis(16384, 16384, 16384);   // non-unit: saturates
    for (int i = 0; i < 4; i++) send('{i[1:0], 16'sd20000, 1'b1}, 1'b1);
    set_axis(0, -16384, 0);
    send('{MODE_DER2, -16'sd3000, 1'b1}, 1'b1);

    // Random phases, each on a fresh axis setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_axis(9459, 9459, 9459);         // ~unit diagonal
        1: set_axis(0, 0, 16384);
        2: set_axis(-16384, -16384, -16384);
        default: set_axis(int'($urandom_range(32768)) - 16384,
                          int'($urandom_range(32768)) - 16384,
                          int'($urandom_range(32768)) - 16384);
      endcase
      no_idle = (ph == 3);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        if (ph == 1 && n == 40) drain();   // sender waits for all results
        send(rand_item(), 1'b1);
      end
    end
    no_idle = 1'b0;

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
